// ===== hdl/sd_spi_command_block_read_core_macros.svh =====
// Assertion helpers for the SD SPI command / block read core.
// All checks are sampled on clk_i and are off while rst_ni is low.
`ifndef SD_SPI_COMMAND_BLOCK_READ_CORE_MACROS_SVH
`define SD_SPI_COMMAND_BLOCK_READ_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SDCBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdcbr check failed");
// next-cycle implication
`define SDCBR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdcbr check failed");
`else
`define SDCBR_ASSERT_IMP(label, ante, cons)
`define SDCBR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/sdcbr_pkg.sv =====
`timescale 1ns / 1ps

package sdcbr_pkg;

  localparam int CmdIdxW  = 6;
  localparam int ArgW     = 32;
  localparam int RespLenW = 3;
  localparam int DataLenW = 10;
  localparam int ByteW    = 8;

  localparam logic [ByteW-1:0] ByteIdle  = 8'hFF;
  localparam logic [ByteW-1:0] TokenData = 8'hFE;
  localparam logic [1:0]       CmdStart  = 2'b01;

  localparam logic [RespLenW-1:0] RespLenMin = 3'd1;
  localparam logic [RespLenW-1:0] RespLenMax = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_CMD,
    PH_RPOLL,
    PH_RESP,
    PH_TOKEN,
    PH_DATA,
    PH_DCRC
  } phase_e;

  typedef enum logic {
    MODE_START,
    MODE_RX
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RESP,
    KIND_DATA
  } rx_kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_RESP,
    ST_NO_TOKEN,
    ST_CRC_ERR
  } status_e;

  typedef struct packed {
    mode_e                mode;
    logic [CmdIdxW-1:0]   cmd_index;
    logic [ArgW-1:0]      argument;
    logic [RespLenW-1:0]  resp_len;
    logic [DataLenW-1:0]  data_len;
    logic [ByteW-1:0]     rx_byte;
  } req_t;

  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             chip_select;
    rx_kind_e         rx_kind;
    logic [ByteW-1:0] rx_value;
    logic             finished;
    status_e          status;
  } res_t;

  // CRC7, polynomial x^7 + x^3 + 1, MSB first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[6] ^ b[i];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ 7'h09;
      end
    end
    return crc;
  endfunction

  // CRC16-CCITT, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ 16'h1021;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== hdl/sd_spi_command_block_read_core.sv =====
`timescale 1ns / 1ps
// SD card SPI-mode command engine with single block read, one byte exchange per request.
// A request is loaded into the input register on acceptance, its result into the result
//   register. Throughput: one request per cycle while the result side is not stalled;
// the transaction state advances once per request.
// Reset (rst_ni low, asynchronous): engine idle, both register stages empty.
`include "sd_spi_command_block_read_core_macros.svh"

module sd_spi_command_block_read_core
  import sdcbr_pkg::*;
#(
  parameter int RESPONSE_POLL_LIMIT = 8,
  parameter int TOKEN_POLL_LIMIT    = 2048,
  parameter int MAX_BLOCK_BYTES     = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [5:0] cmd_index, [37:6] argument, [40:38] resp_len, [50:41] data_len,
  // [58:51] rx_byte, [63:59] zero
  input  logic [63:0] s_axis_tdata_i,
  // [0] mode (0 start, 1 received byte)
  input  logic        s_axis_tuser_i,
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] tx_byte, [8] chip_select, [16:9] rx_value, [18:17] status, [23:19] zero
  output logic [23:0] m_axis_tdata_o,
  // [1:0] rx_kind
  output logic [1:0]  m_axis_tuser_o,
  // finished: this exchange is the last of the transaction
  output logic        m_axis_tlast_o
);

  // Poll counter is shared by the response poll and the token poll.
  localparam int PollMax = (TOKEN_POLL_LIMIT > RESPONSE_POLL_LIMIT) ?
                           TOKEN_POLL_LIMIT : RESPONSE_POLL_LIMIT;
  localparam int PollW   = (PollMax > 1) ? $clog2(PollMax) : 1;
  localparam logic [PollW:0]    RespPollLim  = (PollW+1)'(RESPONSE_POLL_LIMIT);
  localparam logic [PollW:0]    TokenPollLim = (PollW+1)'(TOKEN_POLL_LIMIT);
  localparam logic [DataLenW:0] MaxBlk       = (DataLenW+1)'(MAX_BLOCK_BYTES);
  localparam logic [DataLenW-1:0] CmdLastIdx = DataLenW'(4);
  localparam logic [DataLenW-1:0] CmdCrcIdx  = DataLenW'(5);
  localparam logic [DataLenW-1:0] DataCrcLen = DataLenW'(2);

  // ---------------------------------------------------------------------------
  // Handshake and register stages
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  res_t out_q;
  logic advance;
  logic proc;
  res_t res;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // request payload, unpacked from the bus
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.mode      <= mode_e'(s_axis_tuser_i);
      in_q.cmd_index <= s_axis_tdata_i[5:0];
      in_q.argument  <= s_axis_tdata_i[37:6];
      in_q.resp_len  <= s_axis_tdata_i[40:38];
      in_q.data_len  <= s_axis_tdata_i[50:41];
      in_q.rx_byte   <= s_axis_tdata_i[58:51];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q.status, out_q.rx_value, out_q.chip_select,
                            out_q.tx_byte};
  assign m_axis_tuser_o  = out_q.rx_kind;
  assign m_axis_tlast_o  = out_q.finished;

  // ---------------------------------------------------------------------------
  // Transaction state
  // ---------------------------------------------------------------------------
  phase_e              phase_q, phase_d;
  logic [DataLenW-1:0] byte_count_q, byte_count_d;
  logic [PollW-1:0]    poll_count_q, poll_count_d;
  logic [39:0]         cmd_bytes_q, cmd_bytes_d;
  logic [6:0]          crc7_q, crc7_d;
  logic [15:0]         crc16_q, crc16_d;
  logic [RespLenW-1:0] resp_len_q, resp_len_d;
  logic [DataLenW-1:0] data_len_q, data_len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      byte_count_q <= '0;
      poll_count_q <= '0;
      cmd_bytes_q  <= '0;
      crc7_q       <= '0;
      crc16_q      <= '0;
      resp_len_q   <= '0;
      data_len_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      poll_count_q <= poll_count_d;
      cmd_bytes_q  <= cmd_bytes_d;
      crc7_q       <= crc7_d;
      crc16_q      <= crc16_d;
      resp_len_q   <= resp_len_d;
      data_len_q   <= data_len_d;
    end
  end

  // Shared decode of the current request against the state
  logic [ByteW-1:0]    first_cmd_byte;
  logic [ByteW-1:0]    cur_cmd_byte;
  logic [RespLenW-1:0] rl_sat;
  logic [DataLenW-1:0] dl_sat;
  logic [DataLenW-1:0] byte_inc;
  logic [PollW:0]      poll_inc;
  logic                rx_idle;
  logic                rx_token;
  logic                rpoll_more;
  logic                tpoll_more;
  logic                resp_more;
  logic                data_done;
  logic                dcrc_more;
  logic [15:0]         crc16_next;

  assign first_cmd_byte = {CmdStart, in_q.cmd_index};

  always_comb begin
    unique case (byte_count_q[2:0])
      3'd0:    cur_cmd_byte = cmd_bytes_q[39:32];
      3'd1:    cur_cmd_byte = cmd_bytes_q[31:24];
      3'd2:    cur_cmd_byte = cmd_bytes_q[23:16];
      3'd3:    cur_cmd_byte = cmd_bytes_q[15:8];
      3'd4:    cur_cmd_byte = cmd_bytes_q[7:0];
      default: cur_cmd_byte = '0;
    endcase
  end

  // zero length means one byte, anything above five is five
  always_comb begin
    rl_sat = in_q.resp_len;
    if (in_q.resp_len == '0) begin
      rl_sat = RespLenMin;
    end else if (in_q.resp_len > RespLenMax) begin
      rl_sat = RespLenMax;
    end
  end

  assign dl_sat     = ({1'b0, in_q.data_len} > MaxBlk) ? MaxBlk[DataLenW-1:0] : in_q.data_len;
  assign byte_inc   = byte_count_q + DataLenW'(1);
  assign poll_inc   = {1'b0, poll_count_q} + (PollW+1)'(1);
  assign rx_idle    = (in_q.rx_byte == ByteIdle);
  assign rx_token   = (in_q.rx_byte == TokenData);
  assign rpoll_more = (poll_inc < RespPollLim);
  assign tpoll_more = (poll_inc < TokenPollLim);
  assign resp_more  = (byte_inc < DataLenW'(resp_len_q));
  assign data_done  = (byte_inc >= data_len_q);
  assign dcrc_more  = (byte_inc < DataCrcLen);
  assign crc16_next = crc16_byte(crc16_q, in_q.rx_byte);

  // Next state
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    poll_count_d = poll_count_q;
    cmd_bytes_d  = cmd_bytes_q;
    crc7_d       = crc7_q;
    crc16_d      = crc16_q;
    resp_len_d   = resp_len_q;
    data_len_d   = data_len_q;
    if (proc) begin
      if (in_q.mode == MODE_START) begin
        // a start always wins, any running transaction is dropped
        resp_len_d   = rl_sat;
        data_len_d   = dl_sat;
        cmd_bytes_d  = {first_cmd_byte, in_q.argument};
        crc7_d       = crc7_byte(7'd0, first_cmd_byte);
        crc16_d      = '0;
        poll_count_d = '0;
        byte_count_d = DataLenW'(1);
        phase_d      = PH_CMD;
      end else begin
        unique case (phase_q)
          PH_CMD: begin
            if (byte_count_q <= CmdLastIdx) begin
              crc7_d       = crc7_byte(crc7_q, cur_cmd_byte);
              byte_count_d = byte_inc;
            end else if (byte_count_q == CmdCrcIdx) begin
              byte_count_d = byte_inc;
            end else begin
              phase_d      = PH_RPOLL;
              poll_count_d = '0;
            end
          end
          PH_RPOLL: begin
            if (rx_idle) begin
              if (rpoll_more) begin
                poll_count_d = poll_inc[PollW-1:0];
              end else begin
                phase_d = PH_IDLE;
              end
            end else if (data_len_q != '0) begin
              phase_d      = PH_TOKEN;
              poll_count_d = '0;
            end else if (resp_len_q > RespLenMin) begin
              phase_d      = PH_RESP;
              byte_count_d = DataLenW'(1);
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_RESP: begin
            byte_count_d = byte_inc;
            if (!resp_more) begin
              phase_d = PH_IDLE;
            end
          end
          PH_TOKEN: begin
            if (rx_token) begin
              phase_d      = PH_DATA;
              byte_count_d = '0;
              crc16_d      = '0;
            end else if (tpoll_more) begin
              poll_count_d = poll_inc[PollW-1:0];
            end else begin
              phase_d = PH_IDLE;
            end
          end
          PH_DATA: begin
            crc16_d      = crc16_next;
            byte_count_d = byte_inc;
            if (data_done) begin
              phase_d      = PH_DCRC;
              byte_count_d = '0;
            end
          end
          PH_DCRC: begin
            crc16_d      = crc16_next;
            byte_count_d = byte_inc;
            if (!dcrc_more) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result for the current request
  always_comb begin
    res = '{tx_byte: ByteIdle, chip_select: 1'b1, rx_kind: KIND_NONE,
            rx_value: '0, finished: 1'b0, status: ST_OK};
    if (in_q.mode == MODE_START) begin
      res.tx_byte = first_cmd_byte;
    end else begin
      unique case (phase_q)
        PH_CMD: begin
          if (byte_count_q <= CmdLastIdx) begin
            res.tx_byte = cur_cmd_byte;
          end else if (byte_count_q == CmdCrcIdx) begin
            res.tx_byte = {crc7_q, 1'b1};
          end
        end
        PH_RPOLL: begin
          if (rx_idle) begin
            if (!rpoll_more) begin
              res.chip_select = 1'b0;
              res.finished    = 1'b1;
              res.status      = ST_NO_RESP;
            end
          end else begin
            res.rx_kind  = KIND_RESP;
            res.rx_value = in_q.rx_byte;
            if (data_len_q == '0 && resp_len_q <= RespLenMin) begin
              res.chip_select = 1'b0;
              res.finished    = 1'b1;
            end
          end
        end
        PH_RESP: begin
          res.rx_kind  = KIND_RESP;
          res.rx_value = in_q.rx_byte;
          if (!resp_more) begin
            res.chip_select = 1'b0;
            res.finished    = 1'b1;
          end
        end
        PH_TOKEN: begin
          if (!rx_token && !tpoll_more) begin
            res.chip_select = 1'b0;
            res.finished    = 1'b1;
            res.status      = ST_NO_TOKEN;
          end
        end
        PH_DATA: begin
          res.rx_kind  = KIND_DATA;
          res.rx_value = in_q.rx_byte;
        end
        PH_DCRC: begin
          if (!dcrc_more) begin
            res.chip_select = 1'b0;
            res.finished    = 1'b1;
            res.status      = (crc16_next == '0) ? ST_OK : ST_CRC_ERR;
          end
        end
        default: begin
          // received byte with no transaction running
          res.chip_select = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SDCBR_ASSERT_IMP(a_fin_deselects, out_valid_q && out_q.finished, !out_q.chip_select && out_q.tx_byte == ByteIdle)
  `SDCBR_ASSERT_IMP(a_status_only_fin, out_valid_q && out_q.status != ST_OK, out_q.finished)
  `SDCBR_ASSERT_NXT(a_fin_to_idle, proc && res.finished, phase_q == PH_IDLE)
  `SDCBR_ASSERT_IMP(a_rpoll_bound, phase_q == PH_RPOLL, {1'b0, poll_count_q} < RespPollLim)
  `SDCBR_ASSERT_IMP(a_no_kind_no_val, out_valid_q && out_q.rx_kind == KIND_NONE, out_q.rx_value == '0)

endmodule

// ===== tb/sv/sd_spi_exchange_monitor.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the SD SPI engine. Each accepted request is
// run through a local copy of the engine; the outcome is queued and compared
// field by field against the next accepted result.
module sd_spi_exchange_monitor
  import sdcbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam int RespPollMax  = 8;
  localparam int TokenPollMax = 2048;
  localparam int BlockMax     = 512;

  typedef struct {
    logic [7:0] tx;
    logic       cs;
    rx_kind_e   kind;
    logic [7:0] val;
    logic       fin;
    status_e    st;
  } exchange_t;

  exchange_t predicted_exchanges[$];

  // engine copy
  phase_e      ph;
  logic [9:0]  nbytes;
  logic [11:0] npoll;
  logic [39:0] cmd_word;
  logic [6:0]  crc7_acc;
  logic [15:0] crc16_acc;
  logic [2:0]  rlen;
  logic [9:0]  dlen;

  int n_results;
  int n_mismatch;

  // x^7 + x^3 + 1, one bit at a time, MSB first
  function automatic logic [6:0] crc7_next(input logic [6:0] c, input logic [7:0] b);
    logic [6:0] r;
    logic       fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[6] ^ b[i];
      r  = {r[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
    end
    return r;
  endfunction

  // CCITT polynomial 0x1021, bitwise, MSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [7:0] cmd_byte(input int k);
    return cmd_word[8*(4-k) +: 8];
  endfunction

  function automatic exchange_t make_exchange(input logic [7:0] tx, input logic cs,
                                              input rx_kind_e kind, input logic [7:0] val,
                                              input logic fin, input status_e st);
    exchange_t e;
    e.tx   = tx;
    e.cs   = cs;
    e.kind = kind;
    e.val  = val;
    e.fin  = fin;
    e.st   = st;
    return e;
  endfunction

  function automatic exchange_t step_card_engine(input logic mode, input logic [63:0] d);
    exchange_t  e;
    logic [7:0] rx;
    logic [7:0] b;
    logic [2:0] rl;
    logic [9:0] dl;
    rx = d[58:51];
    e  = make_exchange(ByteIdle, 1'b1, KIND_NONE, 8'h00, 1'b0, ST_OK);
    if (mode_e'(mode) == MODE_START) begin
      rl = d[40:38];
      dl = d[50:41];
      if (rl == 3'd0) rl = RespLenMin;
      if (rl > RespLenMax) rl = RespLenMax;
      if (dl > 10'(BlockMax)) dl = 10'(BlockMax);
      rlen      = rl;
      dlen      = dl;
      cmd_word  = {8'h40 | {2'b00, d[5:0]}, d[37:6]};
      crc7_acc  = crc7_next(7'h00, cmd_byte(0));
      crc16_acc = 16'h0000;
      npoll     = '0;
      nbytes    = 10'd1;
      ph        = PH_CMD;
      e.tx      = cmd_byte(0);
      return e;
    end
    case (ph)
      PH_CMD: begin
        if (nbytes < 10'd5) begin
          b        = cmd_byte(int'(nbytes));
          crc7_acc = crc7_next(crc7_acc, b);
          nbytes   = nbytes + 10'd1;
          e.tx     = b;
        end else if (nbytes == 10'd5) begin
          nbytes = 10'd6;
          e.tx   = {crc7_acc, 1'b1};
        end else begin
          ph    = PH_RPOLL;
          npoll = '0;
        end
      end
      PH_RPOLL: begin
        if (rx == ByteIdle) begin
          if (int'(npoll) + 1 < RespPollMax) begin
            npoll = npoll + 12'd1;
          end else begin
            ph = PH_IDLE;
            e  = make_exchange(ByteIdle, 1'b0, KIND_NONE, 8'h00, 1'b1, ST_NO_RESP);
          end
        end else if (dlen != 10'd0) begin
          ph     = PH_TOKEN;
          npoll  = '0;
          e.kind = KIND_RESP;
          e.val  = rx;
        end else if (rlen > 3'd1) begin
          ph     = PH_RESP;
          nbytes = 10'd1;
          e.kind = KIND_RESP;
          e.val  = rx;
        end else begin
          ph = PH_IDLE;
          e  = make_exchange(ByteIdle, 1'b0, KIND_RESP, rx, 1'b1, ST_OK);
        end
      end
      PH_RESP: begin
        nbytes = nbytes + 10'd1;
        if (nbytes < 10'(rlen)) begin
          e.kind = KIND_RESP;
          e.val  = rx;
        end else begin
          ph = PH_IDLE;
          e  = make_exchange(ByteIdle, 1'b0, KIND_RESP, rx, 1'b1, ST_OK);
        end
      end
      PH_TOKEN: begin
        if (rx == TokenData) begin
          ph        = PH_DATA;
          nbytes    = '0;
          crc16_acc = 16'h0000;
        end else if (int'(npoll) + 1 < TokenPollMax) begin
          npoll = npoll + 12'd1;
        end else begin
          ph = PH_IDLE;
          e  = make_exchange(ByteIdle, 1'b0, KIND_NONE, 8'h00, 1'b1, ST_NO_TOKEN);
        end
      end
      PH_DATA: begin
        crc16_acc = crc16_next(crc16_acc, rx);
        nbytes    = nbytes + 10'd1;
        if (nbytes >= dlen) begin
          ph     = PH_DCRC;
          nbytes = '0;
        end
        e.kind = KIND_DATA;
        e.val  = rx;
      end
      PH_DCRC: begin
        crc16_acc = crc16_next(crc16_acc, rx);
        nbytes    = nbytes + 10'd1;
        if (nbytes >= 10'd2) begin
          ph = PH_IDLE;
          e  = make_exchange(ByteIdle, 1'b0, KIND_NONE, 8'h00, 1'b1,
                             (crc16_acc == 16'h0000) ? ST_OK : ST_CRC_ERR);
        end
      end
      default: begin
        // byte while deselected
        ph   = PH_IDLE;
        e.cs = 1'b0;
      end
    endcase
    return e;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_mismatch++;
    $display("[%0t] result %0d: %s = 0x%0h, predicted 0x%0h", $realtime, n_results, what,
             got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exchange_t want;
    if (!rst_ni) begin
      ph        = PH_IDLE;
      nbytes    = '0;
      npoll     = '0;
      cmd_word  = '0;
      crc7_acc  = '0;
      crc16_acc = '0;
      rlen      = '0;
      dlen      = '0;
      predicted_exchanges.delete();
      n_results  = 0;
      n_mismatch = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predicted_exchanges.push_back(step_card_engine(s_axis_tuser_i, s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (predicted_exchanges.size() == 0) begin
          report_mismatch("unpredicted result, tdata", int'(m_axis_tdata_i), 0);
        end else begin
          want = predicted_exchanges.pop_front();
          if (m_axis_tdata_i[7:0] !== want.tx)
            report_mismatch("tx_byte", int'(m_axis_tdata_i[7:0]), int'(want.tx));
          if (m_axis_tdata_i[8] !== want.cs)
            report_mismatch("chip_select", int'(m_axis_tdata_i[8]), int'(want.cs));
          if (m_axis_tuser_i !== want.kind)
            report_mismatch("rx_kind", int'(m_axis_tuser_i), int'(want.kind));
          if (m_axis_tdata_i[16:9] !== want.val)
            report_mismatch("rx_value", int'(m_axis_tdata_i[16:9]), int'(want.val));
          if (m_axis_tlast_i !== want.fin)
            report_mismatch("finished", int'(m_axis_tlast_i), int'(want.fin));
          if (m_axis_tdata_i[18:17] !== want.st)
            report_mismatch("status", int'(m_axis_tdata_i[18:17]), int'(want.st));
        end
        n_results++;
      end
    end
    mismatches_o  <= n_mismatch;
    outstanding_o <= predicted_exchanges.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the SD SPI command / block read engine. The
// request side plays a card: each transaction is a start request followed by
// the bytes a card would return (don't-care bytes while the command goes out, response polls, response,
// token polls, data block, CRC16). Checking lives in the exchange monitor.
module tb_top
  import sdcbr_pkg::*;
();

  // far above the slowest legal run (~4k requests)
  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 370;
  localparam int HoldCycles = 400;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        s_axis_tvalid_i  = 1'b0;
  logic [63:0] s_axis_tdata_i   = '0;
  logic        s_axis_tuser_i   = 1'b0;
  logic        m_axis_tready_i  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int   mismatches;
  int   outstanding;
  int   src_idle_pct  = 0;  // only read by the stimulus process
  int   sink_idle_pct = 0;  // written by NBA, read by the receiver process
  logic hold_off_tick = 1'b0;
  int   items_sent    = 0;
  int   cycles        = 0;

  always #10 clk_i = ~clk_i;

  sd_spi_command_block_read_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  sd_spi_exchange_monitor exchange_mon (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  // Receiver. A toggle of hold_off_tick starts a long stretch with tready low,
  // counted here, so the two register stages fill and the request side stalls.
  int   hold_left = 0;
  logic seen_tick = 1'b0;
  always @(posedge clk_i) begin
    if (hold_off_tick != seen_tick) begin
      seen_tick = hold_off_tick;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // CRC16-CCITT, init 0; used to build a block trailer the card would send
  function automatic logic [15:0] block_crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    return r;
  endfunction

  // One request. tvalid stays high across back-to-back requests; random gaps
  // drop it first. Handshake seen on the edge where tvalid and tready are high.
  task automatic send_req(input mode_e mode, input logic [5:0] idx, input logic [31:0] arg,
                          input logic [2:0] rl, input logic [9:0] dl, input logic [7:0] rx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, rx, dl, rl, arg, idx};
    s_axis_tuser_i  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // received-byte request; the start-only fields carry junk the engine ignores
  task automatic card_byte(input logic [7:0] rx);
    send_req(MODE_RX, 6'($urandom_range(63)), $urandom, 3'($urandom_range(7)),
             10'($urandom_range(1023)), rx);
  endtask

  // Full card-side sequence for one command.
  //   resp_polls : idle bytes before the response, 8 or more = response timeout
  //   token_polls: non-token bytes before 0xFE, 2048 or more = token timeout
  //   cut        : stop after this many received bytes (abandoned), <0 = all
  task automatic run_transaction(input logic [5:0] idx, input logic [31:0] arg,
                                 input logic [2:0] rl, input logic [9:0] dl,
                                 input int resp_polls, input int token_polls,
                                 input bit bad_crc, input int cut);
    logic [7:0]  card_bytes[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          rl_eff;
    int          dl_eff;
    int          n;
    rl_eff = (rl == 3'd0) ? 1 : ((rl > 3'd5) ? 5 : int'(rl));
    dl_eff = (dl > 10'd512) ? 512 : int'(dl);
    // card output while the six command bytes go out is don't-care
    repeat (6) card_bytes.push_back(8'($urandom_range(255)));
    for (int i = 0; i < resp_polls && i < 8; i++) card_bytes.push_back(ByteIdle);
    if (resp_polls < 8) begin
      card_bytes.push_back(8'($urandom_range(254)));  // R1: anything but idle
      if (dl_eff == 0) begin
        repeat (rl_eff - 1) card_bytes.push_back(8'($urandom_range(255)));
      end else begin
        for (int i = 0; i < token_polls && i < 2048; i++) begin
          b = 8'($urandom_range(255));
          card_bytes.push_back((b == TokenData) ? ByteIdle : b);
        end
        if (token_polls < 2048) begin
          card_bytes.push_back(TokenData);
          crc = 16'h0000;
          repeat (dl_eff) begin
            b   = 8'($urandom_range(255));
            crc = block_crc_step(crc, b);
            card_bytes.push_back(b);
          end
          // appending the CRC big-endian leaves a zero remainder
          if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
          card_bytes.push_back(crc[15:8]);
          card_bytes.push_back(crc[7:0]);
        end
      end
    end
    send_req(MODE_START, idx, arg, rl, dl, 8'($urandom_range(255)));
    n = (cut >= 0 && cut < card_bytes.size()) ? cut : card_bytes.size();
    for (int i = 0; i < n; i++) card_byte(card_bytes[i]);
  endtask

  // Mostly well-formed commands with random content; some timeouts, bad CRCs,
  // abandoned transactions and stray bytes while deselected.
  task automatic random_transaction();
    int         r;
    int         rp;
    int         tp;
    int         cut;
    logic [9:0] dl;
    r = $urandom_range(99);
    if (r < 40) dl = 10'd0;
    else if (r < 85) dl = 10'($urandom_range(1, 24));
    else if (r < 97) dl = 10'($urandom_range(25, 100));
    else dl = 10'($urandom_range(513, 1023));
    r  = $urandom_range(99);
    rp = (r < 8) ? 8 : ((r < 18) ? 7 : $urandom_range(0, 3));
    tp = ($urandom_range(99) < 15) ? $urandom_range(6, 60) : $urandom_range(0, 4);
    cut = ($urandom_range(99) < 8) ? $urandom_range(0, 12) : -1;
    run_transaction(6'($urandom_range(63)), $urandom, 3'($urandom_range(7)), dl, rp, tp,
                    $urandom_range(99) < 15, cut);
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 3)) card_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int phase_end;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bytes while deselected, max index/argument with zero
    // response length (treated as 1), a start that abandons a running
    // command, and a response timeout.
    card_byte(8'hFF);
    card_byte(8'h00);
    run_transaction(6'd63, 32'hFFFF_FFFF, 3'd0, 10'd0, 0, 0, 1'b0, -1);
    run_transaction(6'd0, 32'h0000_0000, 3'd7, 10'd0, 0, 0, 1'b0, 2);
    run_transaction(6'd17, 32'hA5C3_0F96, 3'd3, 10'd0, 8, 0, 1'b0, -1);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct  = 20;
          sink_idle_pct <= 75;
        end
        1: begin
          src_idle_pct  = 75;
          sink_idle_pct <= 20;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
          hold_off_tick <= ~hold_off_tick;  // long receiver stall, sender keeps going
        end
      endcase
      if (p == 0) begin
        // oversize block (saturates to 512) and a token timeout
        run_transaction(6'd17, $urandom, 3'd1, 10'd1023, 1, 3, 1'b0, -1);
        run_transaction(6'd17, $urandom, 3'd1, 10'd8, 0, 2048, 1'b0, -1);
      end
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) random_transaction();
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then let the two register stages settle
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sdcbr_pkg.sv
hdl/sd_spi_command_block_read_core.sv
tb/sv/sd_spi_exchange_monitor.sv
tb/sv/tb_top.sv
